>>> design/crdm_pkg.sv
`default_nettype none
package crdm_pkg;

  // Shared circle geometry handed from the sequencer to every lane
  typedef struct packed {
    logic [16:0] rsq;
    logic [17:0] inner_sq;
    logic [17:0] fade_in_sq;
    logic [17:0] fade_out_sq;
    logic [15:0] dx_sq;
    logic        lit;
  } crdm_geom_t;

  localparam logic [8:0] RING_W = 9'd4;
  localparam logic [8:0] FADE_W = 9'd6;

  // 4x4 Bayer threshold by screen position
  function automatic logic [3:0] bayer_thr(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] t;
    case ({row, col})
      4'h0: t = 4'd0;
      4'h1: t = 4'd8;
      4'h2: t = 4'd2;
      4'h3: t = 4'd10;
      4'h4: t = 4'd12;
      4'h5: t = 4'd4;
      4'h6: t = 4'd14;
      4'h7: t = 4'd6;
      4'h8: t = 4'd3;
      4'h9: t = 4'd11;
      4'hA: t = 4'd1;
      4'hB: t = 4'd9;
      4'hC: t = 4'd15;
      4'hD: t = 4'd7;
      4'hE: t = 4'd13;
      default: t = 4'd5;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

>>> design/crdm_lane.sv
`default_nettype none
module crdm_lane (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  crdm_pkg::crdm_geom_t  geom,
  input  logic signed [11:0]    dy,
  input  logic                  pix,
  input  logic [3:0]            thr,
  output logic                  done,
  output logic                  px_o
);
  import crdm_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_SQ, L_CLS, L_DIV, L_FIN} lane_state_t;

  lane_state_t  state_r;
  logic [21:0]  dy_sq_r;
  logic         outside_r;
  logic         full_r;
  logic [17:0]  rem_r;
  logic [17:0]  den_r;
  logic [3:0]   q_r;
  logic [1:0]   cnt_r;
  logic         done_r;
  logic         px_r;

  logic signed [23:0] dy_prod;
  logic [22:0]        d;
  logic               ring;
  logic               in_fade;
  logic               out_fade;
  logic [22:0]        diff_in;
  logic [22:0]        diff_out;
  logic [18:0]        rem2;
  logic [18:0]        sub;
  logic               ge;

  assign dy_prod  = dy * dy;
  assign d        = {7'd0, geom.dx_sq} + {1'b0, dy_sq_r};
  assign ring     = (d >= {5'd0, geom.inner_sq}) && (d <= {6'd0, geom.rsq});
  assign in_fade  = (d > {5'd0, geom.fade_in_sq}) && (d < {5'd0, geom.inner_sq});
  assign out_fade = (d > {6'd0, geom.rsq}) && (d < {5'd0, geom.fade_out_sq});
  assign diff_in  = d - {5'd0, geom.fade_in_sq};
  assign diff_out = {5'd0, geom.fade_out_sq} - d;
  assign rem2     = {rem_r, 1'b0};
  assign sub      = rem2 - {1'b0, den_r};
  assign ge       = rem2 >= {1'b0, den_r};

  // Square, classify, divide the fade position one quotient bit a cycle, decide
  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        L_IDLE: begin
          if (start) state_r <= L_SQ;
        end
        L_SQ: begin
          dy_sq_r <= dy_prod[21:0];
          state_r <= L_CLS;
        end
        L_CLS: begin
          outside_r <= d > {6'd0, geom.rsq};
          full_r    <= geom.lit && ring;
          q_r       <= 4'd0;
          cnt_r     <= 2'd0;
          if (geom.lit && !ring && in_fade) begin
            rem_r   <= diff_in[17:0];
            den_r   <= geom.inner_sq - geom.fade_in_sq;
            state_r <= L_DIV;
          end else if (geom.lit && !ring && out_fade) begin
            rem_r   <= diff_out[17:0];
            den_r   <= geom.fade_out_sq - {1'b0, geom.rsq};
            state_r <= L_DIV;
          end else begin
            // run a zero divide so every lane finishes in step
            rem_r   <= 18'd0;
            den_r   <= 18'd1;
            state_r <= L_DIV;
          end
        end
        L_DIV: begin
          rem_r <= ge ? sub[17:0] : rem2[17:0];
          q_r   <= {q_r[2:0], ge};
          cnt_r <= cnt_r + 2'd1;
          if (cnt_r == 2'd3) state_r <= L_FIN;
        end
        L_FIN: begin
          if (full_r || (q_r > thr)) px_r <= 1'b1;
          else if (outside_r)         px_r <= 1'b0;
          else                        px_r <= pix;
          done_r  <= 1'b1;
          state_r <= L_IDLE;
        end
        default: state_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign px_o = px_r;

endmodule
`default_nettype wire

>>> design/circular_reveal_dither_mask.sv
`default_nettype none
// Timing is set by the column/page subtract loop, the 9-step root search and the lanes'
// fixed 4-step fade divide. A reveal of 256 or more skips the lanes and goes from idle
// straight to the done state, so the byte passes through unchanged.
// Throughput: one request at a time; the next is taken once the result is latched.
// Reset (rst_n low, synchronous) returns to idle and drops any pending result.
module circular_reveal_dither_mask #(
  parameter int LOGICAL_WIDTH  = 64,
  parameter int LOGICAL_HEIGHT = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_pixels,
  input  logic [9:0] in_byte_index,
  input  logic [8:0] in_reveal,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pixels
);
  import crdm_pkg::*;

  localparam int         CORNER   = (LOGICAL_WIDTH - 1) * (LOGICAL_WIDTH - 1)
                                  + (LOGICAL_HEIGHT - 1) * (LOGICAL_HEIGHT - 1);
  localparam logic [16:0] CORNER_V = 17'(CORNER);
  localparam logic [9:0]  W_V      = 10'(LOGICAL_WIDTH);
  localparam logic [10:0] WM1      = 11'(LOGICAL_WIDTH - 1);
  localparam logic [11:0] HM1      = 12'(LOGICAL_HEIGHT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL1, S_MUL2, S_ROOT, S_FIX, S_GEOM, S_LANE, S_DONE
  } state_t;

  state_t      state_r;
  logic [7:0]  pix_r;
  logic [9:0]  col_r;
  logic [6:0]  page_r;
  logic [7:0]  rev_r;
  logic        lit_r;
  logic [24:0] prod1_r;
  logic [16:0] rsq_r;
  logic [15:0] dx_sq_r;
  logic [8:0]  f_r;
  logic [3:0]  step_r;
  logic [8:0]  rad_r;
  crdm_geom_t  geom_r;
  logic        start_r;
  logic [7:0]  res_r;
  logic        out_valid_r;
  logic [7:0]  out_r;

  logic signed [10:0] dx;
  logic signed [21:0] dx_prod;
  logic [32:0]        prod2;
  logic [8:0]         trial;
  logic [17:0]        trial_sq;
  logic [17:0]        fsq;
  logic [17:0]        rad_sq;
  logic [8:0]         inner;
  logic [8:0]         fade_in;
  logic [9:0]         fade_out;
  logic [19:0]        fade_out_prod;
  logic [7:0]         lane_done;
  logic [7:0]         lane_px;

  assign dx            = $signed({2'b00, col_r[7:0], 1'b0}) - $signed(WM1);
  assign dx_prod       = dx * dx;
  assign prod2         = prod1_r * rev_r;
  assign trial         = f_r | (9'd1 << step_r);
  assign trial_sq      = trial * trial;
  assign fsq           = f_r * f_r;
  assign rad_sq        = rad_r * rad_r;
  assign inner         = (rad_r > RING_W) ? rad_r - RING_W : 9'd0;
  assign fade_in       = (inner > FADE_W) ? inner - FADE_W : 9'd0;
  assign fade_out      = {1'b0, rad_r} + {1'b0, FADE_W};
  assign fade_out_prod = fade_out * fade_out;

  // Sequencer: split the index, scale the radius, search the root, launch lanes
  always_ff @(posedge clk) begin
    start_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pix_r  <= in_pixels;
            res_r  <= in_pixels;
            col_r  <= in_byte_index;
            page_r <= 7'd0;
            rev_r  <= in_reveal[7:0];
            lit_r  <= |in_reveal[7:0];
            state_r <= in_reveal[8] ? S_DONE : S_DIV;
          end
        end
        S_DIV: begin
          if (col_r >= W_V) begin
            col_r  <= col_r - W_V;
            page_r <= page_r + 7'd1;
          end else begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod1_r <= CORNER_V * rev_r;
          dx_sq_r <= dx_prod[15:0];
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          rsq_r   <= prod2[32:16];
          f_r     <= 9'd0;
          step_r  <= 4'd8;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (trial_sq <= {1'b0, rsq_r}) f_r <= trial;
          if (step_r == 4'd0) state_r <= S_FIX;
          else                step_r  <= step_r - 4'd1;
        end
        S_FIX: begin
          rad_r   <= (fsq < {1'b0, rsq_r}) ? f_r + 9'd1 : f_r;
          state_r <= S_GEOM;
        end
        S_GEOM: begin
          geom_r.rsq         <= rsq_r;
          geom_r.inner_sq    <= inner * inner;
          geom_r.fade_in_sq  <= fade_in * fade_in;
          geom_r.fade_out_sq <= fade_out_prod[17:0];
          geom_r.dx_sq       <= dx_sq_r;
          geom_r.lit         <= lit_r;
          start_r            <= 1'b1;
          state_r            <= S_LANE;
        end
        S_LANE: begin
          if (&lane_done) begin
            res_r   <= lane_px;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // One lane per pixel row of the page byte
  for (genvar i = 0; i < 8; i++) begin : g_lane
    logic [9:0]         row;
    logic signed [11:0] dy;
    assign row = {page_r, 3'(i)};
    assign dy  = $signed({1'b0, row, 1'b0}) - $signed(HM1);
    crdm_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start_r),
      .geom  (geom_r),
      .dy    (dy),
      .pix   (pix_r[i]),
      .thr   (bayer_thr(row[1:0], col_r[1:0])),
      .done  (lane_done[i]),
      .px_o  (lane_px[i])
    );
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_pixels = out_r;

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL1) |-> (col_r < W_V))
    else $error("column not reduced below width");
  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (fsq <= {1'b0, rsq_r}))
    else $error("root estimate overshoots");
  a_radius_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEOM) |-> (rad_sq >= {1'b0, rsq_r}))
    else $error("radius below ceiling root");
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done != 8'h00) |-> (lane_done == 8'hFF))
    else $error("lanes finished out of step");
  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_reveal[8]) |=>
      (state_r == S_DONE) && (res_r == $past(in_pixels)))
    else $error("full reveal did not pass the byte");

endmodule
`default_nettype wire
